// ===== sv/assert_macros.svh =====
// assertion helpers, sampled on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/ibrs_pkg.sv =====
package ibrs_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_REPLY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_REQ     = 2'd0,
    ST_DONE    = 2'd1,
    ST_NOSIGN  = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_A   = 2'd1,
    PH_WAIT_B   = 2'd2,
    PH_WAIT_MID = 2'd3
  } phase_e;

endpackage

// ===== sv/integer_bisection_root_search_core.sv =====
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i / in_ready_o | opcode_i endpoint_a_i endpoint_b_i
//         |           |                         | func_value_i
// out     | output    | out_valid_o/out_ready_i | status_o probe_arg_o root_arg_o
//         |           |                         | root_value_o
//
// one result transaction per input transaction, one transaction per cycle sustained while out_ready_i stays high
// an item passes the input register, then the decision logic into the result register
// the sustained rate is set by the search state update, which is computed combinationally
// reset clears the phase to idle, the endpoint and value registers to zero
// a stalled result holds in the output register while one more item waits in the input register
`include "assert_macros.svh"

module integer_bisection_root_search_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ibrs_pkg::opcode_e    opcode_i,
  input  ibrs_pkg::data_t      endpoint_a_i,
  input  ibrs_pkg::data_t      endpoint_b_i,
  input  ibrs_pkg::data_t      func_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ibrs_pkg::status_e    status_o,
  output ibrs_pkg::data_t      probe_arg_o,
  output ibrs_pkg::data_t      root_arg_o,
  output ibrs_pkg::data_t      root_value_o
);
  import ibrs_pkg::*;

  // endpoints more than one apart, distance taken at 33 bits
  function automatic logic far_apart(data_t a, data_t b);
    logic signed [DataW:0] d;
    d = {b[DataW-1], b} - {a[DataW-1], a};
    return (d > 33'sd1) || (d < -33'sd1);
  endfunction

  // midpoint of a 33-bit sum, truncated toward zero
  function automatic data_t mid_of(data_t a, data_t b);
    logic signed [DataW:0] s;
    logic signed [DataW:0] h;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    h = s >>> 1;
    if (s[DataW] && s[0]) begin
      h = h + 33'sd1;
    end
    return h[DataW-1:0];
  endfunction

  // f(lo) + f(hi) > 0, i.e. -f(lo) < f(hi), exact at 33 bits
  function automatic logic sum_pos(data_t a, data_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return !s[DataW] && (s != '0);
  endfunction

  // input register
  logic    in_valid_q;
  opcode_e in_op_q;
  data_t   in_a_q, in_b_q, in_fv_q;

  // search state
  phase_e  phase_q, phase_d;
  data_t   low_end_q, low_end_d;
  data_t   high_end_q, high_end_d;
  data_t   low_value_q, low_value_d;
  data_t   high_value_q, high_value_d;
  data_t   mid_q, mid_d;

  // result register
  logic    out_valid_q;
  status_e res_status_q, res_status_d;
  data_t   res_probe_q, res_probe_d;
  data_t   res_root_q, res_root_d;
  data_t   res_val_q, res_val_d;

  logic    fire;

  // the held item moves on when the result register is free or being emptied
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    phase_d      = phase_q;
    low_end_d    = low_end_q;
    high_end_d   = high_end_q;
    low_value_d  = low_value_q;
    high_value_d = high_value_q;
    mid_d        = mid_q;
    res_status_d = ST_IGNORED;
    res_probe_d  = '0;
    res_root_d   = '0;
    res_val_d    = '0;

    if (in_op_q == OP_START) begin
      // a start drops whatever search is running
      low_end_d    = in_a_q;
      high_end_d   = in_b_q;
      phase_d      = PH_WAIT_A;
      res_status_d = ST_REQ;
      res_probe_d  = in_a_q;
    end else begin
      case (phase_q)
        PH_WAIT_A: begin
          low_value_d  = in_fv_q;
          phase_d      = PH_WAIT_B;
          res_status_d = ST_REQ;
          res_probe_d  = high_end_q;
        end
        PH_WAIT_B: begin
          high_value_d = in_fv_q;
          phase_d      = PH_IDLE;
          if (low_value_q == '0) begin
            res_status_d = ST_DONE;
            res_root_d   = low_end_q;
          end else if (in_fv_q == '0) begin
            res_status_d = ST_DONE;
            res_root_d   = high_end_q;
          end else if ((low_value_q < 0 && in_fv_q > 0) ||
                       (in_fv_q < 0 && low_value_q > 0)) begin
            // distance and midpoint do not care about the order of the ends
            if (in_fv_q < 0) begin
              low_end_d    = high_end_q;
              high_end_d   = low_end_q;
              low_value_d  = in_fv_q;
              high_value_d = low_value_q;
            end
            if (far_apart(low_end_q, high_end_q)) begin
              mid_d        = mid_of(low_end_q, high_end_q);
              phase_d      = PH_WAIT_MID;
              res_status_d = ST_REQ;
              res_probe_d  = mid_of(low_end_q, high_end_q);
            end else begin
              // the magnitude sum is the same whichever end is low
              res_status_d = ST_DONE;
              if (sum_pos(low_value_q, in_fv_q) == (in_fv_q > 0)) begin
                res_root_d = low_end_q;
                res_val_d  = low_value_q;
              end else begin
                res_root_d = high_end_q;
                res_val_d  = in_fv_q;
              end
            end
          end else begin
            res_status_d = ST_NOSIGN;
          end
        end
        PH_WAIT_MID: begin
          phase_d = PH_IDLE;
          if (in_fv_q == '0) begin
            res_status_d = ST_DONE;
            res_root_d   = mid_q;
          end else if (in_fv_q < 0) begin
            // midpoint becomes the low end
            low_end_d   = mid_q;
            low_value_d = in_fv_q;
            if (far_apart(mid_q, high_end_q)) begin
              mid_d        = mid_of(mid_q, high_end_q);
              phase_d      = PH_WAIT_MID;
              res_status_d = ST_REQ;
              res_probe_d  = mid_of(mid_q, high_end_q);
            end else begin
              res_status_d = ST_DONE;
              if (sum_pos(in_fv_q, high_value_q)) begin
                res_root_d = mid_q;
                res_val_d  = in_fv_q;
              end else begin
                res_root_d = high_end_q;
                res_val_d  = high_value_q;
              end
            end
          end else begin
            // midpoint becomes the high end
            high_end_d   = mid_q;
            high_value_d = in_fv_q;
            if (far_apart(low_end_q, mid_q)) begin
              mid_d        = mid_of(low_end_q, mid_q);
              phase_d      = PH_WAIT_MID;
              res_status_d = ST_REQ;
              res_probe_d  = mid_of(low_end_q, mid_q);
            end else begin
              res_status_d = ST_DONE;
              if (sum_pos(low_value_q, in_fv_q)) begin
                res_root_d = low_end_q;
                res_val_d  = low_value_q;
              end else begin
                res_root_d = mid_q;
                res_val_d  = in_fv_q;
              end
            end
          end
        end
        default: begin
          // reply with no search running: flagged, state untouched
          res_status_d = ST_IGNORED;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_op_q <= opcode_i;
      in_a_q  <= endpoint_a_i;
      in_b_q  <= endpoint_b_i;
      in_fv_q <= func_value_i;
    end
  end

  // search state, updated once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      low_end_q    <= '0;
      high_end_q   <= '0;
      low_value_q  <= '0;
      high_value_q <= '0;
      mid_q        <= '0;
    end else if (fire) begin
      phase_q      <= phase_d;
      low_end_q    <= low_end_d;
      high_end_q   <= high_end_d;
      low_value_q  <= low_value_d;
      high_value_q <= high_value_d;
      mid_q        <= mid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= res_status_d;
      res_probe_q  <= res_probe_d;
      res_root_q   <= res_root_d;
      res_val_q    <= res_val_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_status_q;
  assign probe_arg_o  = res_probe_q;
  assign root_arg_o   = res_root_q;
  assign root_value_o = res_val_q;

  logic search_end;
  logic idle_reply;

  assign search_end = fire && (res_status_d != ST_REQ);
  assign idle_reply = fire && (in_op_q == OP_REPLY) && (phase_q == PH_IDLE);

  // a finished or failed search always leaves the controller idle
  `ASSERT_AT(a_end_to_idle, search_end |=> (phase_q == PH_IDLE), "search end not idle")
  // a reply with no search running is flagged as ignored
  `ASSERT_AT(a_idle_reply, idle_reply |=> (out_valid_o && status_o == ST_IGNORED), "not ignored")
  // only evaluate requests carry a probe argument
  `ASSERT_NEVER(a_probe_clean, out_valid_o && status_o != ST_REQ && probe_arg_o != '0, "stray probe")

endmodule
